// ----- hdl/pkfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkfd_pkg - shared types and constants for the path/keyframe deframer
// Result item layout, result kinds and default caps.
// ----------------------------------------------------------------------------
package pkfd_pkg;

	localparam int PKFD_PATH_CAP   = 32;
	localparam int PKFD_KF_CAP     = 16;
	localparam int MAX_RESULTS     = 4;	// path step, two keyframes, end item
	localparam int QUEUE_DEPTH     = 8;

	localparam int NIBBLE_W   = 4;
	localparam int PTOTAL_W   = 5;
	localparam int KTOTAL_W   = 4;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 16;

	typedef enum logic [1:0] {
		KIND_PATH     = 2'd0,
		KIND_KEYFRAME = 2'd1,
		KIND_END      = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [NIBBLE_W-1:0]   value;
		logic [PTOTAL_W-1:0]   path_total;
		logic [KTOTAL_W-1:0]   keyframe_total;
		logic                  last;
	} result_t;

	// Results caused by one accepted nibble, packed from item[0] upward
	typedef struct packed {
		logic [2:0]                   count;
		result_t [MAX_RESULTS-1:0]    item;
	} push_t;

endpackage

// ----- hdl/pkfd_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkfd_decode - message state and per-nibble result generation
// Holds the pending nibbles, phase flag and counts; turns one nibble into
// zero to four result items in a single pass.
// ----------------------------------------------------------------------------
module pkfd_decode #(
	parameter int PATH_CAP = pkfd_pkg::PKFD_PATH_CAP,
	parameter int KF_CAP   = pkfd_pkg::PKFD_KF_CAP
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [pkfd_pkg::NIBBLE_W-1:0] nibble,
	input  logic                          final_nibble,
	output pkfd_pkg::push_t               push
);
	import pkfd_pkg::*;

	localparam int PC_W = $clog2(PATH_CAP);
	localparam int KC_W = $clog2(KF_CAP);

	logic [NIBBLE_W-1:0] pend0_q, pend1_q, pend0_d, pend1_d;
	logic [1:0]          pend_cnt_q, pend_cnt_d;
	logic                kf_phase_q, kf_phase_d;
	logic [PC_W-1:0]     path_cnt_q, path_cnt_n;
	logic [KC_W-1:0]     kf_cnt_q, kf_cnt_1, kf_cnt_n;

	logic                path_try, a_try, b_try;
	logic [NIBBLE_W-1:0] path_val, a_val, b_val;
	logic                path_ok, a_ok, b_ok;
	result_t [MAX_RESULTS-1:0] slot;
	logic [MAX_RESULTS-1:0]    slot_v;

	// Phase and pending-nibble handling
	always_comb begin
		pend0_d    = pend0_q;
		pend1_d    = pend1_q;
		pend_cnt_d = pend_cnt_q;
		kf_phase_d = kf_phase_q;
		path_try   = 1'b0;
		path_val   = pend0_q;
		a_try      = 1'b0;
		a_val      = nibble;
		b_try      = 1'b0;
		b_val      = nibble;
		if (kf_phase_q) begin
			a_try = 1'b1;
		end else if (!pend_cnt_q[1]) begin
			if (pend_cnt_q == 2'd0) begin
				pend0_d    = nibble;
				pend_cnt_d = 2'd1;
				a_try      = final_nibble;
			end else begin
				pend1_d    = nibble;
				pend_cnt_d = 2'd2;
				a_try      = final_nibble;
				a_val      = pend0_q;
				b_try      = final_nibble;
			end
		end else if (pend0_q == '0 && pend1_q == '0 && nibble == '0) begin
			// terminator: three zero nibbles
			kf_phase_d = 1'b1;
			pend_cnt_d = 2'd0;
		end else begin
			path_try = 1'b1;
			pend0_d  = pend1_q;
			pend1_d  = nibble;
			a_try    = final_nibble;
			a_val    = pend1_q;
			b_try    = final_nibble;
		end
	end

	// Caps and counts, keyframe tries in order
	assign path_ok    = path_try && (path_cnt_q < PC_W'(PATH_CAP - 1));
	assign path_cnt_n = path_cnt_q + PC_W'(path_ok);
	assign a_ok       = a_try && (a_val != '0) && (kf_cnt_q < KC_W'(KF_CAP - 1));
	assign kf_cnt_1   = kf_cnt_q + KC_W'(a_ok);
	assign b_ok       = b_try && (b_val != '0) && (kf_cnt_1 < KC_W'(KF_CAP - 1));
	assign kf_cnt_n   = kf_cnt_1 + KC_W'(b_ok);

	always_comb begin
		slot[0] = '{kind: KIND_PATH, value: path_val, path_total: '0,
			keyframe_total: '0, last: 1'b0};
		slot[1] = '{kind: KIND_KEYFRAME, value: a_val, path_total: '0,
			keyframe_total: '0, last: 1'b0};
		slot[2] = '{kind: KIND_KEYFRAME, value: b_val, path_total: '0,
			keyframe_total: '0, last: 1'b0};
		slot[3] = '{kind: KIND_END, value: '0, path_total: PTOTAL_W'(path_cnt_n),
			keyframe_total: KTOTAL_W'(kf_cnt_n), last: 1'b1};
		slot_v  = {final_nibble, b_ok, a_ok, path_ok};
	end

	// Pack the valid slots from item[0] up
	always_comb begin
		logic [2:0] pos;
		pos       = 3'd0;
		push.item = '0;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (slot_v[i]) begin
				push.item[pos[1:0]] = slot[i];
				pos                 = pos + 3'd1;
			end
		end
		push.count = accept ? pos : 3'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend0_q    <= '0;
			pend1_q    <= '0;
			pend_cnt_q <= '0;
			kf_phase_q <= 1'b0;
			path_cnt_q <= '0;
			kf_cnt_q   <= '0;
		end else if (accept) begin
			if (final_nibble) begin
				pend0_q    <= '0;
				pend1_q    <= '0;
				pend_cnt_q <= '0;
				kf_phase_q <= 1'b0;
				path_cnt_q <= '0;
				kf_cnt_q   <= '0;
			end else begin
				pend0_q    <= pend0_d;
				pend1_q    <= pend1_d;
				pend_cnt_q <= pend_cnt_d;
				kf_phase_q <= kf_phase_d;
				path_cnt_q <= path_cnt_n;
				kf_cnt_q   <= kf_cnt_n;
			end
		end
	end

	a_kf_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		kf_phase_q |-> pend_cnt_q == 2'd0)
		else $error("pending nibbles held in keyframe phase");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && final_nibble |=> !kf_phase_q && pend_cnt_q == 2'd0 &&
			path_cnt_q == '0 && kf_cnt_q == '0)
		else $error("state not cleared after end of message");

	a_caps: assert property (@(posedge clk) disable iff (!arst_n)
		path_cnt_q <= PC_W'(PATH_CAP - 1) && kf_cnt_q <= KC_W'(KF_CAP - 1))
		else $error("count beyond cap");

endmodule

// ----- hdl/pkfd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkfd_queue - result item queue
// Takes up to four items per cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
module pkfd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  pkfd_pkg::push_t   push,
	output logic              room,
	output logic              out_valid,
	input  logic              out_ready,
	output pkfd_pkg::result_t out_item
);
	import pkfd_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	result_t          mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign out_valid = (count_q != '0);
	assign out_item  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	// room for a full burst from one nibble
	assign room      = (count_q <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS));

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (3'(i) < push.count) begin
				mem_q[wr_ptr_q + PTR_W'(i)] <= push.item[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.count);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("result queue overflow");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 3'd0 |-> room)
		else $error("push without room");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		pop && push.count == 3'd0 |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("pop did not drain queue");

endmodule

// ----- hdl/path_keyframe_nibble_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_keyframe_nibble_deframer - nibble stream to path steps and keyframes
// Splits each message into path steps (before a three-zero-nibble
// terminator) and nonzero keyframes (after it), closing with an end item.
// ----------------------------------------------------------------------------
// One nibble is taken per transfer on the slave side, one result item leaves
// per transfer on the master side. The decoder works on a nibble in the cycle
// it is accepted and writes the zero to four result items it causes into an
// eight-entry queue, so a nibble can be accepted every cycle as long as the
// queue has room for four items; a nibble that yields at most one item keeps
// that rate with the master side ready. Results are queued in registers by
// the transfer that caused them; bursts drain at one item per cycle while the
// master side is ready; this sets the long-run rate when results are many.
// Path steps are capped at PATH_CAP-1 and keyframes at KF_CAP-1 per message;
// further ones are consumed silently. The end item (tlast high) carries both
// counts and the block then starts a new message.
module path_keyframe_nibble_deframer #(
	parameter int PATH_CAP = pkfd_pkg::PKFD_PATH_CAP,
	parameter int KF_CAP   = pkfd_pkg::PKFD_KF_CAP
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// slave side
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [pkfd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [3:0] nibble, [7:4] zero
	input  logic                             s_axis_tlast,  // final_nibble
	// master side
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [pkfd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [3:0] value,
	                                                         // [8:4] path_total,
	                                                         // [12:9] keyframe_total,
	                                                         // [15:13] zero
	output logic [1:0]                       m_axis_tuser,  // [1:0] kind
	output logic                             m_axis_tlast   // last
);
	import pkfd_pkg::*;

	logic    accept;
	logic    room;
	push_t   push;
	result_t out_item;

	// tready is high whenever the queue can hold a full burst
	assign s_axis_tready = room;
	assign accept        = s_axis_tvalid && room;

	pkfd_decode #(
		.PATH_CAP (PATH_CAP),
		.KF_CAP   (KF_CAP)
	) u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.nibble       (s_axis_tdata[NIBBLE_W-1:0]),
		.final_nibble (s_axis_tlast),
		.push         (push)
	);

	pkfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (out_item)
	);

	// pack result fields, first field lowest
	assign m_axis_tdata = {3'b000, out_item.keyframe_total, out_item.path_total,
		out_item.value};
	assign m_axis_tuser = out_item.kind;
	assign m_axis_tlast = out_item.last;

endmodule

// ----- tb/path_keyframe_nibble_deframer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_keyframe_nibble_deframer_tb - self-checking bench for the deframer
// Drives nibble messages on the slave stream and checks every master-side
// item against an in-bench model of the path/keyframe split. The sequence is
// short hand-picked messages, cap limits, a full-rate stretch, then random
// messages. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module path_keyframe_nibble_deframer_tb;
	import pkfd_pkg::*;

	localparam int PATH_CAP     = PKFD_PATH_CAP;
	localparam int KF_CAP       = PKFD_KF_CAP;
	localparam int IDLE_PCT     = 29;
	// nibbles sent over the whole run; random messages fill up to this
	localparam int TOTAL_ITEMS  = 330;
	localparam int SETTLE_CYCLES = 20;
	// ~330 nibbles, at most four items each, every item behind a random
	// stall; this sits many times over the slowest passing run
	localparam int CYCLE_LIMIT  = 100000;

	logic                   clk    = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;	// [3:0] nibble, [7:4] zero
	logic                   s_axis_tlast  = 1'b0;	// final_nibble
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;	// [3:0] value, [8:4] path_total,
						// [12:9] keyframe_total, [15:13] zero
	logic [1:0]             m_axis_tuser;	// [1:0] kind
	logic                   m_axis_tlast;	// last

	// random idling on each side; cleared for the full-rate stretch
	bit sender_may_idle = 1'b1;
	bit sink_may_stall  = 1'b1;

	int unsigned cycle_count = 0;
	int unsigned nibbles_sent = 0;
	int unsigned items_seen = 0;
	int unsigned mismatches = 0;

	// model state: mirrors the decoder for the message in flight
	logic [3:0] held_nib [2];
	int         held_cnt;
	bit         after_term;
	int         step_cnt;
	int         key_cnt;

	// items the decoder owes us, oldest first
	result_t    awaited_items [$];

	path_keyframe_nibble_deframer #(
		.PATH_CAP(PATH_CAP),
		.KF_CAP  (KF_CAP)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always #6 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d items still owed",
				cycle_count, awaited_items.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// master-side backpressure: ready drops in about IDLE_PCT of cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !sink_may_stall || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic clear_message_state();
		held_nib[0] = '0;
		held_nib[1] = '0;
		held_cnt    = 0;
		after_term  = 1'b0;
		step_cnt    = 0;
		key_cnt     = 0;
	endtask

	task automatic queue_item(input kind_t kind, input logic [3:0] value,
			input logic last);
		result_t item;
		item.kind           = kind;
		item.value          = value;
		item.path_total     = last ? PTOTAL_W'(step_cnt) : '0;
		item.keyframe_total = last ? KTOTAL_W'(key_cnt) : '0;
		item.last           = last;
		awaited_items.push_back(item);
	endtask

	// zero nibbles never become keyframes; past the cap they are dropped
	task automatic keyframe_candidate(input logic [3:0] nib);
		if (nib != 4'd0 && key_cnt < KF_CAP - 1) begin
			key_cnt++;
			queue_item(KIND_KEYFRAME, nib, 1'b0);
		end
	endtask

	// What one accepted nibble turns into
	task automatic deframe_nibble(input logic [3:0] nib, input logic fin);
		if (after_term) begin
			keyframe_candidate(nib);
		end else if (held_cnt < 2) begin
			// still filling the two-deep window; a message this short
			// hands everything it holds over as keyframes
			held_nib[held_cnt] = nib;
			held_cnt++;
			if (fin) begin
				for (int i = 0; i < held_cnt; i++)
					keyframe_candidate(held_nib[i]);
			end
		end else if (held_nib[0] == 4'd0 && held_nib[1] == 4'd0 && nib == 4'd0) begin
			// three zeros in a row: terminator, window is discarded
			after_term = 1'b1;
			held_cnt   = 0;
		end else begin
			if (step_cnt < PATH_CAP - 1) begin
				step_cnt++;
				queue_item(KIND_PATH, held_nib[0], 1'b0);
			end
			held_nib[0] = held_nib[1];
			held_nib[1] = nib;
			if (fin) begin
				keyframe_candidate(held_nib[0]);
				keyframe_candidate(held_nib[1]);
			end
		end
		if (fin) begin
			queue_item(KIND_END, 4'd0, 1'b1);
			clear_message_state();
		end
	endtask

	// One slave-side transfer. Entered and left on a rising edge; valid
	// stays high between back-to-back nibbles. tready is looked at on the
	// falling edge, where it already holds the value the next edge sees.
	task automatic send_nibble(input logic [3:0] nib, input logic fin);
		while (sender_may_idle && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'd0, nib};
		s_axis_tlast  <= fin;
		@(negedge clk);
		while (!s_axis_tready)
			@(negedge clk);
		@(posedge clk);
		deframe_nibble(nib, fin);
		nibbles_sent++;
	endtask

	// Sender holds off until the decoder owes nothing
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited_items.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [3:0] pick_nibble(input int zero_pct);
		if ($urandom_range(99) < zero_pct)
			return 4'd0;
		return 4'($urandom_range(15, 1));
	endfunction

	// path nibbles, then optionally terminator and keyframe nibbles; the
	// last nibble of whatever is sent carries the final flag
	task automatic send_message(input int path_len, input int kf_len,
			input int zero_pct, input bit terminate);
		int total;
		int idx;
		total = path_len + (terminate ? 3 + kf_len : 0);
		if (total == 0)
			total = 1;
		for (idx = 0; idx < total; idx++) begin
			if (idx < path_len || !terminate)
				send_nibble(pick_nibble(zero_pct), idx == total - 1);
			else if (idx < path_len + 3)
				send_nibble(4'd0, idx == total - 1);
			else
				send_nibble(pick_nibble(zero_pct), idx == total - 1);
		end
	endtask

	// Hand-picked messages: extremes, every kind, each special case
	task automatic test_directed_cases();
		// single-nibble messages, nonzero and zero
		send_nibble(4'hF, 1'b1);
		send_nibble(4'h0, 1'b1);
		// terminator lands on the final nibble
		send_nibble(4'h0, 1'b0); send_nibble(4'h0, 1'b0); send_nibble(4'h0, 1'b1);
		// ends in path phase: one step, two keyframes, end item
		send_nibble(4'h1, 1'b0); send_nibble(4'h2, 1'b0); send_nibble(4'h3, 1'b1);
		// path steps including zeros, then keyframes with a zero skipped
		send_nibble(4'h0, 1'b0); send_nibble(4'h0, 1'b0); send_nibble(4'h5, 1'b0);
		send_nibble(4'h0, 1'b0); send_nibble(4'h0, 1'b0); send_nibble(4'h0, 1'b0);
		send_nibble(4'hF, 1'b0); send_nibble(4'h0, 1'b0); send_nibble(4'h3, 1'b1);
		// two-nibble short message with a trailing zero
		send_nibble(4'h8, 1'b0); send_nibble(4'h0, 1'b1);
		// terminator followed by nothing but zeros
		send_nibble(4'h0, 1'b0); send_nibble(4'h0, 1'b0); send_nibble(4'h0, 1'b0);
		send_nibble(4'h0, 1'b0); send_nibble(4'h0, 1'b1);
	endtask

	// Path and keyframe counts below, at and past their caps
	task automatic test_count_caps();
		send_message(PATH_CAP - 2, KF_CAP - 2, 0, 1'b1);
		send_message(PATH_CAP - 1, KF_CAP - 1, 0, 1'b1);
		send_message(PATH_CAP + 8, KF_CAP + 4, 0, 1'b1);
		// path cap hit in a message that never terminates
		send_message(PATH_CAP + 2, 0, 0, 1'b0);
	endtask

	// No idling on either side: back-to-back transfers and bursts
	task automatic test_full_rate();
		wait_for_results();
		sender_may_idle = 1'b0;
		sink_may_stall  = 1'b0;
		repeat (8)
			send_message($urandom_range(6), $urandom_range(5), 20, 1'b1);
		send_message(3, 0, 30, 1'b0);
		sender_may_idle = 1'b1;
		sink_may_stall  = 1'b1;
	endtask

	// Mostly well-formed messages with random content, some cut short
	// before a terminator and some zero-heavy noise, until the run has
	// sent its nibbles
	task automatic test_random_messages();
		int          pick;
		int          path_len;
		int          kf_len;
		while (nibbles_sent < TOTAL_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				path_len = ($urandom_range(99) < 8) ? $urandom_range(40, 26)
					: $urandom_range(8);
				kf_len   = ($urandom_range(99) < 8) ? $urandom_range(20, 13)
					: $urandom_range(6);
				send_message(path_len, kf_len, 25, 1'b1);
			end else if (pick < 85) begin
				send_message($urandom_range(6, 1), 0, 40, 1'b0);
			end else begin
				// dense zeros often form a terminator by chance
				send_message($urandom_range(14, 1), 0, 65, 1'b0);
			end
			if ($urandom_range(99) < 6)
				wait_for_results();
		end
	endtask

	// Master-side checker. Sampled on the falling edge: valid, ready and
	// the payload are stable there up to the edge that takes the transfer.
	always @(negedge clk) begin : check_items
		result_t want;
		if (arst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
			items_seen++;
			if (awaited_items.size() == 0) begin
				report_mismatch($sformatf("item %0d unexpected: tuser=%0d tdata=%h tlast=%b",
					items_seen, m_axis_tuser, m_axis_tdata, m_axis_tlast));
			end else begin
				want = awaited_items.pop_front();
				if (m_axis_tuser !== want.kind)
					report_mismatch($sformatf("item %0d kind %0d, want %0d",
						items_seen, m_axis_tuser, want.kind));
				if (m_axis_tdata[3:0] !== want.value)
					report_mismatch($sformatf("item %0d value %0d, want %0d",
						items_seen, m_axis_tdata[3:0], want.value));
				if (m_axis_tdata[8:4] !== want.path_total)
					report_mismatch($sformatf("item %0d path_total %0d, want %0d",
						items_seen, m_axis_tdata[8:4], want.path_total));
				if (m_axis_tdata[12:9] !== want.keyframe_total)
					report_mismatch($sformatf("item %0d keyframe_total %0d, want %0d",
						items_seen, m_axis_tdata[12:9], want.keyframe_total));
				if (m_axis_tdata[15:13] !== 3'd0)
					report_mismatch($sformatf("item %0d tdata pad bits %b",
						items_seen, m_axis_tdata[15:13]));
				if (m_axis_tlast !== want.last)
					report_mismatch($sformatf("item %0d last %b, want %b",
						items_seen, m_axis_tlast, want.last));
			end
		end
	end

	initial begin
		clear_message_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_count_caps();
		test_full_rate();
		test_random_messages();

		// drain, then give the decoder time to show any stray item
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
